/* hw/rtl/tcns_pkg.sv */
// shared constants and types for the tick count to nanoseconds converter
`default_nettype none

package tcns_pkg;

  // width of tick counts, frequencies and nanosecond values
  localparam int unsigned DataW = 64;
  // width of the status code
  localparam int unsigned StatusW = 2;
  // width of one billion
  localparam int unsigned NsW = 30;
  // width of a quotient or remainder that passed the scale check
  localparam int unsigned ScaledW = 35;

  localparam logic [NsW-1:0] NsPerSec = NsW'(1000000000);
  // largest value that can be scaled by one billion without overflow
  localparam logic [DataW-1:0] ScaleLimit = 64'd18446744073;
  localparam logic [DataW-1:0] FreqReset = 64'd10000000;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusZeroFreq = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* hw/rtl/tcns_div_pipe.sv */
// restoring divider pipeline, one quotient bit per stage, with sideband payload
`default_nettype none

module tcns_div_pipe #(
  parameter int unsigned Width = tcns_pkg::DataW,
  parameter int unsigned SideW = tcns_pkg::StatusW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [Width-1:0] num_i,
  input  wire logic [Width-1:0] den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic      [Width-1:0] quo_o,
  output logic      [Width-1:0] rem_o,
  output logic      [SideW-1:0] side_o
);
  import tcns_pkg::*;

  // stage k holds the partial remainder and the dividend bits still to shift,
  // with quotient bits filling in from the bottom
  logic             valid_q [Width];
  logic [Width-1:0] rem_q   [Width];
  logic [Width-1:0] nq_q    [Width];
  logic [SideW-1:0] side_q  [Width];

  logic             valid_d [Width];
  logic [Width-1:0] rem_d   [Width];
  logic [Width-1:0] nq_d    [Width];
  logic [SideW-1:0] side_d  [Width];

  always_comb begin
    logic [Width-1:0] rem_in;
    logic [Width-1:0] nq_in;
    logic [Width:0]   trial;
    logic [Width:0]   diff;
    logic             ge;
    for (int k = 0; k < Width; k++) begin
      if (k == 0) begin
        valid_d[k] = valid_i;
        rem_in     = '0;
        nq_in      = num_i;
        side_d[k]  = side_i;
      end else begin
        valid_d[k] = valid_q[k-1];
        rem_in     = rem_q[k-1];
        nq_in      = nq_q[k-1];
        side_d[k]  = side_q[k-1];
      end
      trial    = {rem_in, nq_in[Width-1]};
      diff     = trial - {1'b0, den_i};
      ge       = (trial >= {1'b0, den_i});
      rem_d[k] = ge ? diff[Width-1:0] : trial[Width-1:0];
      nq_d[k]  = {nq_in[Width-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Width; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < Width; k++) begin
        valid_q[k] <= valid_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Width; k++) begin
        rem_q[k]  <= rem_d[k];
        nq_q[k]   <= nq_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = valid_q[Width-1];
  assign quo_o   = nq_q[Width-1];
  assign rem_o   = rem_q[Width-1];
  assign side_o  = side_q[Width-1];

endmodule

`default_nettype wire

/* hw/rtl/tcns_scale.sv */
// range check and scaling of quotient and remainder by one billion
`default_nettype none

module tcns_scale (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [tcns_pkg::DataW-1:0]   quo_i,
  input  wire logic [tcns_pkg::DataW-1:0]   rem_i,
  input  wire tcns_pkg::status_e            status_i,
  output logic                              valid_o,
  output logic      [tcns_pkg::DataW-1:0]   whole_o,
  output logic      [tcns_pkg::DataW-1:0]   prod_o,
  output tcns_pkg::status_e                 status_o
);
  import tcns_pkg::*;

  // check stage
  logic               valid_a_q;
  logic [ScaledW-1:0] q_a_q;
  logic [ScaledW-1:0] r_a_q;
  status_e            st_a_q;
  status_e            st_a_d;
  logic               too_big;

  // whole seconds scaling stage
  logic                   valid_b_q;
  logic [DataW-1:0]       whole_b_q;
  logic [ScaledW-1:0]     r_b_q;
  status_e                st_b_q;
  logic [ScaledW+NsW-1:0] whole_full;

  // remainder scaling stage
  logic                   valid_c_q;
  logic [DataW-1:0]       whole_c_q;
  logic [DataW-1:0]       prod_c_q;
  status_e                st_c_q;
  logic [ScaledW+NsW-1:0] prod_full;

  assign too_big = (quo_i > ScaleLimit) || (rem_i > ScaleLimit);
  assign st_a_d  = (status_i == StatusOk && too_big) ? StatusOverflow : status_i;

  assign whole_full = q_a_q * NsPerSec;
  assign prod_full  = r_b_q * NsPerSec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_a_q     <= quo_i[ScaledW-1:0];
      r_a_q     <= rem_i[ScaledW-1:0];
      st_a_q    <= st_a_d;
      whole_b_q <= whole_full[DataW-1:0];
      r_b_q     <= r_a_q;
      st_b_q    <= st_a_q;
      whole_c_q <= whole_b_q;
      prod_c_q  <= prod_full[DataW-1:0];
      st_c_q    <= st_b_q;
    end
  end

  assign valid_o  = valid_c_q;
  assign whole_o  = whole_c_q;
  assign prod_o   = prod_c_q;
  assign status_o = st_c_q;

endmodule

`default_nettype wire

/* hw/rtl/tcns_out_buf.sv */
// output register with skid entry so the pipeline is decoupled from the sink
`default_nettype none

module tcns_out_buf #(
  parameter int unsigned Width = tcns_pkg::DataW + tcns_pkg::StatusW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [Width-1:0] in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output logic      [Width-1:0] out_data_o,
  input  wire logic             out_stall_i
);
  import tcns_pkg::*;

  logic             out_valid_q;
  logic             out_valid_d;
  logic [Width-1:0] out_data_q;
  logic             skid_valid_q;
  logic             skid_valid_d;
  logic [Width-1:0] skid_data_q;
  logic             take;
  logic             push;
  logic             load_out;
  logic             load_skid;

  assign take = out_valid_q && !out_stall_i;
  assign push = in_valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (skid_valid_q) begin
      if (take) begin
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= in_data_i;
    end else if (skid_valid_q && take) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= in_data_i;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* hw/rtl/tick_count_to_nanoseconds.sv */
// top level of the tick count to nanoseconds converter
`default_nettype none

// converts a 64-bit tick count into nanoseconds using the tick frequency held
// in the configuration register (reset value ten million ticks per second).
// the count is divided by the frequency, the quotient and remainder are each
// checked against (2^64 - 1) / one billion and scaled by one billion, and the
// scaled remainder is divided by the frequency again; the two parts are then
// summed. status reports 0 ok, 1 zero frequency, 2 arithmetic overflow, and
// nanoseconds reads zero whenever status is not ok. one transaction is taken
// every cycle while the sink keeps up. an accepted input transaction enters the
// first of 132 pipeline stages (two 64-stage restoring dividers with one
// quotient bit per stage, the check stage, two multiply stages and the final
// sum stage), and the result leaves the last stage into the output register,
// from which it is offered. the whole pipeline stops only while the skid
// entry beside the output register is full.
// the frequency register may only be written while no transaction is in
// flight, since the dividers read it directly.

module tick_count_to_nanoseconds (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [tcns_pkg::DataW-1:0]   cfg_wdata_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [tcns_pkg::DataW-1:0]   tick_count_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [tcns_pkg::DataW-1:0]   nanoseconds_o,
  output logic      [tcns_pkg::StatusW-1:0] status_o
);
  import tcns_pkg::*;

  localparam int unsigned Side2W = DataW + StatusW;
  localparam int unsigned OutW   = DataW + StatusW;

  // tick frequency register
  logic [DataW-1:0] freq_q;

  // whole pipeline moves together; it holds only while the skid entry is full
  logic pipe_en;
  logic buf_stall;

  // first divider: count / freq
  logic               div1_valid;
  logic [DataW-1:0]   div1_quo;
  logic [DataW-1:0]   div1_rem;
  logic [StatusW-1:0] div1_side;
  status_e            st_in;

  // scaling
  logic             sc_valid;
  logic [DataW-1:0] sc_whole;
  logic [DataW-1:0] sc_prod;
  status_e          sc_status;

  // second divider: (r * 1e9) / freq, whole part and status ride along
  logic              div2_valid;
  logic [DataW-1:0]  div2_quo;
  logic [Side2W-1:0] div2_side;
  logic [DataW-1:0]  whole2;
  status_e           st2;

  // final sum stage
  logic               fin_valid_q;
  logic [DataW-1:0]   fin_ns_q;
  status_e            fin_st_q;
  logic [DataW:0]     sum;
  status_e            fin_st_d;
  logic [DataW-1:0]   fin_ns_d;
  logic [OutW-1:0]    out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FreqReset;
    end else if (cfg_we_i) begin
      freq_q <= cfg_wdata_i;
    end
  end

  assign pipe_en    = !buf_stall;
  assign in_stall_o = buf_stall;

  // zero frequency is flagged on entry and carried with the transaction
  assign st_in = (freq_q == '0) ? StatusZeroFreq : StatusOk;

  tcns_div_pipe #(
    .Width (DataW),
    .SideW (StatusW)
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .num_i   (tick_count_i),
    .den_i   (freq_q),
    .side_i  (st_in),
    .valid_o (div1_valid),
    .quo_o   (div1_quo),
    .rem_o   (div1_rem),
    .side_o  (div1_side)
  );

  tcns_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (div1_valid),
    .quo_i    (div1_quo),
    .rem_i    (div1_rem),
    .status_i (status_e'(div1_side)),
    .valid_o  (sc_valid),
    .whole_o  (sc_whole),
    .prod_o   (sc_prod),
    .status_o (sc_status)
  );

  // the remainder of the second division is not needed
  tcns_div_pipe #(
    .Width (DataW),
    .SideW (Side2W)
  ) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sc_valid),
    .num_i   (sc_prod),
    .den_i   (freq_q),
    .side_i  ({sc_whole, sc_status}),
    .valid_o (div2_valid),
    .quo_o   (div2_quo),
    .rem_o   (),
    .side_o  (div2_side)
  );

  assign whole2 = div2_side[Side2W-1:StatusW];
  assign st2    = status_e'(div2_side[StatusW-1:0]);

  // sum the scaled parts; a carry out means the result does not fit
  assign sum      = {1'b0, whole2} + {1'b0, div2_quo};
  assign fin_st_d = (st2 == StatusOk && sum[DataW]) ? StatusOverflow : st2;
  assign fin_ns_d = (fin_st_d == StatusOk) ? sum[DataW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (pipe_en) begin
      fin_valid_q <= div2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fin_ns_q <= fin_ns_d;
      fin_st_q <= fin_st_d;
    end
  end

  // output register plus skid entry; in_stall only rises once the skid is used
  tcns_out_buf #(
    .Width (OutW)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fin_valid_q),
    .in_data_i   ({fin_ns_q, fin_st_q}),
    .in_stall_o  (buf_stall),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .out_stall_i (out_stall_i)
  );

  assign nanoseconds_o = out_data[OutW-1:StatusW];
  assign status_o      = out_data[StatusW-1:0];

endmodule

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for the tick count to nanoseconds converter
`timescale 1ns / 1ps

module tb_top;
  import tcns_pkg::*;

  // conversion constants, kept apart from the design's own
  localparam logic [63:0] NanosPerSecond = 64'd1000000000;
  localparam logic [63:0] ScaleCeiling   = 64'hFFFF_FFFF_FFFF_FFFF / NanosPerSecond;
  localparam logic [63:0] ResetFrequency = 64'd10000000;
  localparam logic [63:0] AllOnes        = 64'hFFFF_FFFF_FFFF_FFFF;

  // receiver hold-off long enough to fill the whole pipeline (about 133 deep)
  localparam int HoldoffCycles = 400;
  // settle time after the last result, a bit over the pipeline latency
  localparam int SettleCycles  = 200;

  typedef struct packed {
    logic [63:0] ns;
    status_e     status;
  } conversion_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] tick_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] nanoseconds_o;
  logic [1:0]  status_o;

  // counts waiting to be offered, and conversions waiting to come out
  logic [63:0] tick_backlog[$];
  conversion_t pending_conversions[$];

  // testbench copy of the frequency register
  logic [63:0] tick_freq = ResetFrequency;

  logic in_taken = 1'b0;
  // no random idling on either side while set
  logic calm = 1'b0;
  // raised by the sequencer, served by the receiver process
  logic holdoff_request = 1'b0;
  int   holdoff_left = 0;

  int mismatches = 0;
  int checked_ok = 0;
  int checked_zero_freq = 0;
  int checked_overflow = 0;
  int freq_settings = 1;

  tick_count_to_nanoseconds DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tick_count_i  (tick_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .nanoseconds_o (nanoseconds_o),
    .status_o      (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // expected conversion of one count at a given frequency
  function automatic conversion_t ns_from_ticks(logic [63:0] count, logic [63:0] freq);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] whole;
    logic [63:0] frac;
    conversion_t res;
    res.ns = '0;
    res.status = StatusOk;
    if (freq == 64'd0) begin
      res.status = StatusZeroFreq;
    end else begin
      q = count / freq;
      r = count % freq;
      // both halves must scale by one billion without wrapping
      if (q > ScaleCeiling || r > ScaleCeiling) begin
        res.status = StatusOverflow;
      end else begin
        whole = q * NanosPerSecond;
        frac = (r * NanosPerSecond) / freq;
        if (whole > AllOnes - frac) begin
          res.status = StatusOverflow;
        end else begin
          res.ns = whole + frac;
        end
      end
    end
    return res;
  endfunction

  // random count, mostly built from a quotient and remainder that scale cleanly
  function automatic logic [63:0] pick_count(logic [63:0] freq);
    logic [127:0] wide;
    logic [63:0] q;
    logic [63:0] r;
    int unsigned choice;
    choice = $urandom_range(0, 9);
    if (choice < 2 || freq == 64'd0) begin
      return {$urandom, $urandom};
    end else if (choice == 2) begin
      return 64'($urandom_range(0, 255));
    end
    if (choice == 3) begin
      // quotient right around the scaling ceiling
      q = ScaleCeiling + 64'($urandom_range(0, 2)) - 64'd1;
      r = $urandom_range(0, 1) ? freq - 64'd1 : {$urandom, $urandom} % freq;
    end else if (choice == 4) begin
      q = 64'($urandom_range(0, 1000));
      r = {$urandom, $urandom} % freq;
    end else begin
      q = {$urandom, $urandom} % (ScaleCeiling + 64'd1);
      r = {$urandom, $urandom} % freq;
    end
    wide = 128'(q) * 128'(freq) + 128'(r);
    if (wide[127:64] != '0) begin
      return {$urandom, $urandom};
    end
    return wide[63:0];
  endfunction

  // sender: keeps the payload while stalled, otherwise offers the next count or idles at random
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (tick_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
        in_valid_i <= 1'b1;
        tick_count_i <= tick_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (holdoff_request) begin
      holdoff_request = 1'b0;
      holdoff_left = HoldoffCycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  // monitor: predicts on each input transaction, checks each output transaction
  always @(posedge clk_i) begin : monitor
    conversion_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        pending_conversions.push_back(ns_from_ticks(tick_count_i, tick_freq));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_conversions.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result ns=%0d status=%0d", $time, nanoseconds_o,
                   status_o);
        end else begin
          want = pending_conversions.pop_front();
          if (nanoseconds_o !== want.ns) begin
            mismatches++;
            $display("%0t: nanoseconds expected %0d actual %0d", $time, want.ns,
                     nanoseconds_o);
          end
          if (status_o !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d (%s) actual %0d", $time, want.status,
                     want.status.name(), status_o);
          end
          case (want.status)
            StatusOk:       checked_ok++;
            StatusZeroFreq: checked_zero_freq++;
            default:        checked_overflow++;
          endcase
        end
      end
    end
  end

  // returns once every queued count went in and every conversion came out
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (tick_backlog.size() != 0 || in_valid_i || pending_conversions.size() != 0);
  endtask

  // frequency writes only happen with the pipeline empty
  task automatic set_freq(logic [63:0] freq);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= freq;
    @(posedge clk_i);
    tick_freq = freq;
    freq_settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    #1;
  endtask

  task automatic random_phase(logic [63:0] freq, int count);
    set_freq(freq);
    for (int i = 0; i < count; i++) begin
      tick_backlog.push_back(pick_count(freq));
    end
    drain();
  endtask

  // run watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #1;

    // reset frequency of ten million: zero, one, just below and at a full
    // second, the largest count, a quotient at and one past the ceiling, and a
    // count whose two scaled parts overflow only in the sum
    tick_backlog.push_back(64'd0);
    tick_backlog.push_back(64'd1);
    tick_backlog.push_back(ResetFrequency - 64'd1);
    tick_backlog.push_back(ResetFrequency);
    tick_backlog.push_back(AllOnes);
    tick_backlog.push_back((ScaleCeiling + 64'd1) * ResetFrequency);
    tick_backlog.push_back(ScaleCeiling * ResetFrequency + ResetFrequency - 64'd1);
    tick_backlog.push_back(ScaleCeiling * ResetFrequency);
    drain();

    // zero frequency fails every conversion
    set_freq(64'd0);
    tick_backlog.push_back(64'd0);
    tick_backlog.push_back(AllOnes);
    tick_backlog.push_back(64'h5A5A_A5A5_0F0F_F0F0);

    // frequency of one: quotient equals the count, remainder always zero
    set_freq(64'd1);
    tick_backlog.push_back(64'd0);
    tick_backlog.push_back(ScaleCeiling);
    tick_backlog.push_back(ScaleCeiling + 64'd1);
    tick_backlog.push_back(AllOnes);

    // largest frequency: a remainder too large overflows even where the result would fit
    set_freq(AllOnes);
    tick_backlog.push_back(AllOnes - 64'd1);
    tick_backlog.push_back(AllOnes);
    tick_backlog.push_back(ScaleCeiling);
    tick_backlog.push_back(ScaleCeiling + 64'd1);
    drain();

    // random part across a spread of frequencies
    random_phase(ResetFrequency, 80);
    random_phase(64'd1, 80);
    calm = 1'b1;
    random_phase(64'd24000000, 80);
    calm = 1'b0;
    random_phase(64'd0, 80);
    random_phase(AllOnes, 80);

    // receiver holds off while the sender keeps pushing, so the pipeline fills
    // and back-pressures the input
    set_freq(64'd19200000);
    holdoff_request = 1'b1;
    for (int i = 0; i < 170; i++) begin
      tick_backlog.push_back(pick_count(64'd19200000));
    end
    drain();

    random_phase(NanosPerSecond, 80);
    random_phase(64'($urandom_range(2, 32'hFFFF_FFFF)), 80);
    random_phase({$urandom, $urandom}, 80);
    random_phase(64'd3, 80);
    random_phase(ScaleCeiling, 80);
    random_phase(ScaleCeiling + 64'd1, 80);
    random_phase(ResetFrequency, 80);

    // anything still coming out now was never expected
    repeat (SettleCycles) @(posedge clk_i);

    $display("checked %0d conversions over %0d frequency settings", checked_ok +
             checked_zero_freq + checked_overflow, freq_settings);
    $display("  %0d ok, %0d zero frequency, %0d overflow, %0d mismatches", checked_ok,
             checked_zero_freq, checked_overflow, mismatches);
    if (mismatches == 0 && pending_conversions.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tcns_pkg.sv
hw/rtl/tcns_div_pipe.sv
hw/rtl/tcns_scale.sv
hw/rtl/tcns_out_buf.sv
hw/rtl/tick_count_to_nanoseconds.sv
test/tb_top.sv
